/* rtl/pidsr_pkg.sv */
// ----------------------------------------------------------------------------
// pidsr_pkg
// Shared types and constants of the PID speed regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pidsr_pkg;

  localparam int unsigned GainW   = 8;
  localparam int unsigned LimitW  = 7;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned TargetW = 7;
  localparam int unsigned MeasW   = 8;
  localparam int unsigned StateW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [GainW-1:0]  PropGainRst  = 8'd8;
  localparam logic [GainW-1:0]  IntegGainRst = 8'd10;
  localparam logic [GainW-1:0]  DerivGainRst = 8'd1;
  localparam logic [LimitW-1:0] IntegLimRst  = 7'd40;
  localparam logic [DutyW-1:0]  MaxDutyRst   = 16'd400;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_MAX_DUTY    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [GainW-1:0]  prop_gain;
    logic [GainW-1:0]  integ_gain;
    logic [GainW-1:0]  deriv_gain;
    logic [LimitW-1:0] integ_limit;
    logic [DutyW-1:0]  max_duty;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/pidsr_core.sv */
// ----------------------------------------------------------------------------
// pidsr_core
// One control tick: saturated error, clamped integral, error change, weighted
// sum and duty clamp, with the next state; a zero target clears all outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module pidsr_core import pidsr_pkg::*; (
  input  cfg_t               cfg_i,
  input  logic [TargetW-1:0] target_speed_i,
  input  logic [MeasW-1:0]   measured_speed_i,
  input  logic [StateW-1:0]  integ_i,
  input  logic [StateW-1:0]  prev_err_i,
  output logic [DutyW-1:0]   duty_o,
  output logic [StateW-1:0]  integ_o,
  output logic [StateW-1:0]  prev_err_o
);

  logic signed [8:0]  diff;
  logic signed [7:0]  err;
  logic signed [8:0]  isum;
  logic signed [8:0]  lim;
  logic signed [7:0]  integ_new;
  logic signed [8:0]  derr;
  logic signed [18:0] p_term;
  logic signed [18:0] i_term;
  logic signed [18:0] d_term;
  logic signed [18:0] u;
  logic signed [18:0] max_ext;

  always_comb begin
    diff = $signed({2'b00, target_speed_i}) - $signed({1'b0, measured_speed_i});
    if (diff < -9'sd128) begin
      err = -8'sd128;
    end else begin
      err = diff[7:0];
    end

    isum = $signed({integ_i[StateW-1], integ_i}) + $signed({err[7], err});
    lim  = $signed({2'b00, cfg_i.integ_limit});
    if (isum > lim) begin
      integ_new = lim[7:0];
    end else if (isum < -lim) begin
      integ_new = 8'(-lim);
    end else begin
      integ_new = isum[7:0];
    end

    derr = $signed({err[7], err}) - $signed({prev_err_i[StateW-1], prev_err_i});

    p_term = $signed({11'd0, cfg_i.prop_gain}) * $signed({{11{err[7]}}, err});
    i_term = $signed({11'd0, cfg_i.integ_gain}) * $signed({{11{integ_new[7]}}, integ_new});
    d_term = $signed({11'd0, cfg_i.deriv_gain}) * $signed({{10{derr[8]}}, derr});
    u      = p_term + i_term + d_term;

    max_ext = $signed({3'd0, cfg_i.max_duty});

    if (target_speed_i == '0) begin
      duty_o     = '0;
      integ_o    = '0;
      prev_err_o = '0;
    end else begin
      integ_o    = integ_new;
      prev_err_o = err;
      if (u <= 19'sd0) begin
        duty_o = '0;
      end else if (u > max_ext) begin
        duty_o = cfg_i.max_duty;
      end else begin
        duty_o = u[DutyW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/pid_speed_regulator.sv */
// ----------------------------------------------------------------------------
// pid_speed_regulator
// PID speed regulator with a clamped integral and a clamped duty output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one control tick: a
//   target speed and a measured speed. Output channel (out_valid_o /
//   out_stall_i) returns one duty command per tick, in tick order.
//   The tick is captured in an input register; the control law runs on it
//   combinationally and lands in the duty register when the output side
//   advances. One tick per cycle is sustained while the receiver does not
//   stall; the integral and previous-error registers update with the duty
//   register. When the receiver stalls, the duty register holds, the input
//   register fills, and in_stall_o rises only once both are occupied. Gains,
//   integral limit and maximum duty are written through cfg_we_i, cfg_index_i
//   and cfg_wdata_i, by the user only while no tick is in flight (the block
//   does not enforce it). Unknown indexes are ignored. Reset loads default
//   gains and limits, clears the controller state and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_speed_regulator import pidsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [TargetW-1:0]  target_speed_i,
  input  logic [MeasW-1:0]    measured_speed_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DutyW-1:0]    duty_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t               cfg_q;
  logic               s1_valid_q;
  logic [TargetW-1:0] s1_target_q;
  logic [MeasW-1:0]   s1_meas_q;
  logic               out_valid_q;
  logic [DutyW-1:0]   duty_q;
  logic [DutyW-1:0]   duty_d;
  logic [StateW-1:0]  integ_q;
  logic [StateW-1:0]  integ_d;
  logic [StateW-1:0]  prev_q;
  logic [StateW-1:0]  prev_d;
  logic               advance;
  logic               fire;
  logic               in_xfer;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= PropGainRst;
      cfg_q.integ_gain  <= IntegGainRst;
      cfg_q.deriv_gain  <= DerivGainRst;
      cfg_q.integ_limit <= IntegLimRst;
      cfg_q.max_duty    <= MaxDutyRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_wdata_i[GainW-1:0];
        REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_wdata_i[GainW-1:0];
        REG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_wdata_i[GainW-1:0];
        REG_INTEG_LIMIT: cfg_q.integ_limit <= cfg_wdata_i[LimitW-1:0];
        REG_MAX_DUTY:    cfg_q.max_duty    <= cfg_wdata_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance || !s1_valid_q) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_target_q <= target_speed_i;
      s1_meas_q   <= measured_speed_i;
    end
  end

  pidsr_core u_core (
    .cfg_i            (cfg_q),
    .target_speed_i   (s1_target_q),
    .measured_speed_i (s1_meas_q),
    .integ_i          (integ_q),
    .prev_err_i       (prev_q),
    .duty_o           (duty_d),
    .integ_o          (integ_d),
    .prev_err_o       (prev_d)
  );

  // Controller state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        integ_q <= integ_d;
        prev_q  <= prev_d;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      duty_q <= duty_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while a stage was free");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(integ_q) && $stable(prev_q)))
    else $error("controller state changed without a tick");

  a_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (s1_target_q == '0)) |=> ((integ_q == '0) && (prev_q == '0) && (duty_q == '0)))
    else $error("zero setpoint did not clear the controller");

  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a tick");

  a_duty_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (duty_q <= cfg_q.max_duty))
    else $error("duty above maximum");

endmodule

`default_nettype wire

/* tb/sv/pid_speed_regulator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_speed_regulator_tb
// Self-checking bench for the PID speed regulator. A directed table covers
// the zero setpoint, saturated errors, integral limits, duty clamps and
// register masking. Random phases follow, each under a new register setting.
// Every duty is compared with an in-bench control-law model or a typed value.
// ----------------------------------------------------------------------------
module pid_speed_regulator_tb;
  import pidsr_pkg::*;

  localparam int unsigned RandPhases    = 6;
  localparam int unsigned ItemsPerPhase = 325;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned CycleLimit    = 400000;

  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd5;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_TICK_TYPED,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [TargetW-1:0]  target;
    logic [MeasW-1:0]    meas;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] data;
  } dir_row_t;

  localparam int unsigned DirRows = 36;

  dir_row_t dir_rows [DirRows] = '{
    '{ROW_TICK_TYPED, 7'd0,   8'd255, RegUnmapped,     16'd0},
    '{ROW_TICK_TYPED, 7'd127, 8'd0,   RegUnmapped,     16'd400},
    '{ROW_TICK_TYPED, 7'd1,   8'd255, RegUnmapped,     16'd0},
    '{ROW_TICK_TYPED, 7'd127, 8'd127, RegUnmapped,     16'd0},
    '{ROW_TICK_TYPED, 7'd0,   8'd0,   RegUnmapped,     16'd0},
    '{ROW_TICK,       7'd10,  8'd5,   RegUnmapped,     16'd0},
    '{ROW_TICK,       7'd20,  8'd30,  RegUnmapped,     16'd0},
    '{ROW_TICK,       7'd127, 8'd255, RegUnmapped,     16'd0},
    '{ROW_TICK,       7'd64,  8'd64,  RegUnmapped,     16'd0},
    '{ROW_CFG,        7'd0,   8'd0,   RegUnmapped,     16'hFFFF},
    '{ROW_CFG,        7'd0,   8'd0,   REG_INTEG_LIMIT, 16'hFF80},
    '{ROW_TICK,       7'd100, 8'd0,   RegUnmapped,     16'd0},
    '{ROW_TICK,       7'd100, 8'd0,   RegUnmapped,     16'd0},
    '{ROW_CFG,        7'd0,   8'd0,   REG_INTEG_LIMIT, 16'd127},
    '{ROW_CFG,        7'd0,   8'd0,   REG_PROP_GAIN,   16'd255},
    '{ROW_CFG,        7'd0,   8'd0,   REG_INTEG_GAIN,  16'd255},
    '{ROW_CFG,        7'd0,   8'd0,   REG_DERIV_GAIN,  16'd255},
    '{ROW_CFG,        7'd0,   8'd0,   REG_MAX_DUTY,    16'd65535},
    '{ROW_TICK,       7'd127, 8'd0,   RegUnmapped,     16'd0},
    '{ROW_TICK,       7'd127, 8'd0,   RegUnmapped,     16'd0},
    '{ROW_CFG,        7'd0,   8'd0,   REG_INTEG_LIMIT, 16'd5},
    '{ROW_TICK,       7'd50,  8'd40,  RegUnmapped,     16'd0},
    '{ROW_CFG,        7'd0,   8'd0,   REG_MAX_DUTY,    16'd0},
    '{ROW_TICK_TYPED, 7'd127, 8'd0,   RegUnmapped,     16'd0},
    '{ROW_CFG,        7'd0,   8'd0,   REG_PROP_GAIN,   16'd0},
    '{ROW_CFG,        7'd0,   8'd0,   REG_INTEG_GAIN,  16'd0},
    '{ROW_CFG,        7'd0,   8'd0,   REG_DERIV_GAIN,  16'd0},
    '{ROW_CFG,        7'd0,   8'd0,   REG_MAX_DUTY,    16'hFFFF},
    '{ROW_TICK_TYPED, 7'd127, 8'd0,   RegUnmapped,     16'd0},
    '{ROW_CFG,        7'd0,   8'd0,   REG_PROP_GAIN,   16'hAB08},
    '{ROW_CFG,        7'd0,   8'd0,   REG_INTEG_GAIN,  16'h550A},
    '{ROW_CFG,        7'd0,   8'd0,   REG_DERIV_GAIN,  16'hFF01},
    '{ROW_CFG,        7'd0,   8'd0,   REG_INTEG_LIMIT, 16'h00A8},
    '{ROW_CFG,        7'd0,   8'd0,   REG_MAX_DUTY,    16'd400},
    '{ROW_TICK,       7'd3,   8'd200, RegUnmapped,     16'd0},
    '{ROW_TICK_TYPED, 7'd0,   8'd17,  RegUnmapped,     16'd0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [TargetW-1:0]  target_speed_i;
  logic [MeasW-1:0]    measured_speed_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [DutyW-1:0]    duty_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  cfg_t                     ctl_cfg;
  logic signed [StateW-1:0] integ_state;
  logic signed [StateW-1:0] prev_err_state;
  logic [DutyW-1:0]         duty_expect_q [$];

  int          fail_count = 0;
  int          holds_requested = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned max_gap = 4;
  logic        valid_up = 1'b0;

  pid_speed_regulator DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .target_speed_i   (target_speed_i),
    .measured_speed_i (measured_speed_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .duty_o           (duty_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [DutyW-1:0] step_regulator(input logic [TargetW-1:0] tgt,
                                                      input logic [MeasW-1:0] meas);
    int err, acc, lim, diff, drive;
    if (tgt == '0) begin
      integ_state    = '0;
      prev_err_state = '0;
      return '0;
    end
    err = int'(tgt) - int'(meas);
    if (err < -128) err = -128;
    lim = int'(ctl_cfg.integ_limit);
    acc = int'(integ_state) + err;
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    diff  = err - int'(prev_err_state);
    drive = int'(ctl_cfg.prop_gain) * err + int'(ctl_cfg.integ_gain) * acc +
            int'(ctl_cfg.deriv_gain) * diff;
    integ_state    = acc[StateW-1:0];
    prev_err_state = err[StateW-1:0];
    if (drive <= 0) return '0;
    if (drive > int'(ctl_cfg.max_duty)) return ctl_cfg.max_duty;
    return drive[DutyW-1:0];
  endfunction

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PROP_GAIN:   ctl_cfg.prop_gain   = val[GainW-1:0];
      REG_INTEG_GAIN:  ctl_cfg.integ_gain  = val[GainW-1:0];
      REG_DERIV_GAIN:  ctl_cfg.deriv_gain  = val[GainW-1:0];
      REG_INTEG_LIMIT: ctl_cfg.integ_limit = val[LimitW-1:0];
      REG_MAX_DUTY:    ctl_cfg.max_duty    = val[DutyW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_tick(input logic [TargetW-1:0] tgt, input logic [MeasW-1:0] meas,
                           input logic typed, input logic [DutyW-1:0] typed_duty);
    logic [DutyW-1:0] predicted;
    int unsigned      gap;
    in_valid_i       <= 1'b1;
    target_speed_i   <= tgt;
    measured_speed_i <= meas;
    valid_up = 1'b1;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predicted = step_regulator(tgt, meas);
    duty_expect_q.push_back(typed ? typed_duty : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(0, max_gap);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        valid_up = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic settle();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
    while (duty_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] pick_setting(input logic [CfgDataW-1:0] mask,
                                                       input logic [CfgDataW-1:0] rst_val);
    logic [CfgDataW-1:0] val;
    case ($urandom_range(0, 4))
      0:       val = '0;
      1:       val = mask;
      2:       val = rst_val;
      default: val = CfgDataW'($urandom_range(0, int'(mask)));
    endcase
    return val | (CfgDataW'($urandom) & ~mask);
  endfunction

  always @(posedge clk_i) begin : duty_check
    logic [DutyW-1:0] want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (duty_expect_q.size() == 0) begin
        $display("%0t: duty transfer with none expected, actual %0d", $time, duty_o);
        fail_count++;
      end else begin
        want = duty_expect_q.pop_front();
        if (duty_o !== want) begin
          $display("%0t: duty mismatch, expected %0d, actual %0d", $time, want, duty_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : receiver
    int          served;
    int unsigned hold_left;
    int unsigned pct;
    int unsigned phase_left;
    served     = 0;
    hold_left  = 0;
    pct        = 0;
    phase_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && served != holds_requested) begin
        served++;
        hold_left = HoldCycles;
      end
      if (phase_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    pct = 0;
          2:       pct = 25;
          3:       pct = 50;
          default: pct = 85;
        endcase
        phase_left = $urandom_range(10, 120);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL pid_speed_regulator");
    $finish;
  end

  initial begin : stimulus
    logic [TargetW-1:0] tgt;
    logic [MeasW-1:0]   meas;
    int                 near;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    target_speed_i   = '0;
    measured_speed_i = '0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = '0;
    cfg_wdata_i      = '0;
    ctl_cfg          = '{PropGainRst, IntegGainRst, DerivGainRst, IntegLimRst, MaxDutyRst};
    integ_state      = '0;
    prev_err_state   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_CFG: begin
          settle();
          cfg_write(dir_rows[r].cfg_idx, dir_rows[r].data);
        end
        ROW_TICK_TYPED: send_tick(dir_rows[r].target, dir_rows[r].meas, 1'b1,
                                  dir_rows[r].data);
        default: send_tick(dir_rows[r].target, dir_rows[r].meas, 1'b0, '0);
      endcase
    end

    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      settle();
      cfg_write(REG_PROP_GAIN,   pick_setting(16'h00FF, 16'(PropGainRst)));
      cfg_write(REG_INTEG_GAIN,  pick_setting(16'h00FF, 16'(IntegGainRst)));
      cfg_write(REG_DERIV_GAIN,  pick_setting(16'h00FF, 16'(DerivGainRst)));
      cfg_write(REG_INTEG_LIMIT, pick_setting(16'h007F, 16'(IntegLimRst)));
      cfg_write(REG_MAX_DUTY,    pick_setting(16'hFFFF, MaxDutyRst));
      cfg_write(CfgIdxW'($urandom_range(int'(RegUnmapped), 7)), CfgDataW'($urandom));
      max_gap = (ph % 3 == 0) ? 0 : $urandom_range(2, 8);
      if (ph == 1 || ph == 4) holds_requested <= holds_requested + 1;
      repeat (ItemsPerPhase) begin
        tgt = ($urandom_range(0, 11) == 0) ? '0 : TargetW'($urandom_range(1, 127));
        if ($urandom_range(0, 2) == 0) begin
          meas = MeasW'($urandom);
        end else begin
          near = int'(tgt) + $urandom_range(0, 40) - 20;
          if (near < 0) near = 0;
          meas = near[MeasW-1:0];
        end
        send_tick(tgt, meas, 1'b0, '0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS pid_speed_regulator");
    end else begin
      $display("FAIL pid_speed_regulator");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/pidsr_pkg.sv
rtl/pidsr_core.sv
rtl/pid_speed_regulator.sv
tb/sv/pid_speed_regulator_tb.sv
